// ===== src/kps_pkg.sv =====
package kps_pkg;

    // Rows of the full matrix mode and lines of the wide direct mode
    localparam int MATRIX_ROWS = 8;
    localparam int SENSE_WIDTH = 16;

    localparam int SENSE_W  = 16;
    localparam int MAX_ROWS = (MATRIX_ROWS > 4) ? MATRIX_ROWS : 4;
    localparam int PHASE_W  = $clog2(MAX_ROWS + 2);
    localparam int ROW_BITS = (MATRIX_ROWS >= 8) ? 8 : MATRIX_ROWS;

    localparam logic [1:0] MODE_MATRIX_FULL = 2'd0;
    localparam logic [1:0] MODE_MATRIX_4X4  = 2'd1;
    localparam logic [1:0] MODE_DIRECT_8    = 2'd2;
    localparam logic [1:0] MODE_DIRECT_WIDE = 2'd3;

    localparam logic [7:0] DRIVE_NONE      = 8'hFF;
    localparam logic [7:0] IDLE_DRIVE_FULL = ~8'((1 << ROW_BITS) - 1);
    localparam logic [7:0] IDLE_DRIVE_4X4  = 8'hF0;

    localparam logic [4:0] LINES_8     = 5'd8;
    localparam logic [4:0] LINES_4     = 5'd4;
    localparam logic [4:0] LINES_WIDE  = 5'(SENSE_WIDTH);

    localparam logic [PHASE_W-1:0] ROWS_FULL = PHASE_W'(MATRIX_ROWS);
    localparam logic [PHASE_W-1:0] ROWS_4X4  = PHASE_W'(4);
    localparam logic [PHASE_W-1:0] PHASE_MAX = PHASE_W'(MAX_ROWS + 1);

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [7:0]         previous_code;
        logic [7:0]         reported_code;
    } kps_state_t;

    typedef struct packed {
        logic [7:0] row_drive;
        logic       scan_done;
        logic [7:0] scan_code;
        logic       report;
    } kps_result_t;

    // 1-based position of the lowest low line among the low n lines, 0 if none
    function automatic logic [4:0] first_low(logic [SENSE_W-1:0] lines, logic [4:0] n);
        logic [4:0] pos;
        pos = '0;
        for (int i = SENSE_W - 1; i >= 0; i--)
        begin
            if ((i < int'(n)) && !lines[i])
            begin
                pos = 5'(i + 1);
            end
        end
        return pos;
    endfunction

endpackage

// ===== src/kps_step.sv =====
module kps_step
    import kps_pkg::*;
(
    input  logic [1:0]         mode,
    input  logic [SENSE_W-1:0] sense,
    input  kps_state_t         cur,
    output kps_state_t         nxt,
    output kps_result_t        res
);

    logic [PHASE_W-1:0] rows;
    logic [PHASE_W-1:0] row;
    logic [7:0]         row8;
    logic [7:0]         idle_drive;
    logic [4:0]         col;
    logic [4:0]         direct_pos;
    logic               done;
    logic [7:0]         code;
    logic [7:0]         drive;
    logic [PHASE_W-1:0] phase_next;

    assign rows       = (mode == MODE_MATRIX_FULL) ? ROWS_FULL : ROWS_4X4;
    assign idle_drive = (mode == MODE_MATRIX_FULL) ? IDLE_DRIVE_FULL : IDLE_DRIVE_4X4;
    assign col        = first_low(sense, (mode == MODE_MATRIX_FULL) ? LINES_8 : LINES_4);
    assign direct_pos = first_low(sense, (mode == MODE_DIRECT_8) ? LINES_8 : LINES_WIDE);
    assign row        = cur.phase - PHASE_W'(1);
    assign row8       = 8'(row);

    always_comb
    begin
        done       = 1'b0;
        code       = '0;
        drive      = DRIVE_NONE;
        phase_next = cur.phase;
        unique case (mode)
            MODE_DIRECT_8, MODE_DIRECT_WIDE:
            begin
                done       = 1'b1;
                code       = 8'(direct_pos);
                phase_next = '0;
            end
            MODE_MATRIX_FULL, MODE_MATRIX_4X4:
            begin
                priority if (cur.phase == '0)
                begin
                    // idle read: any low column starts a row walk
                    if (col == '0)
                    begin
                        done  = 1'b1;
                        drive = idle_drive;
                    end
                    else
                    begin
                        phase_next = PHASE_W'(1);
                    end
                end
                else if (cur.phase > rows + PHASE_W'(1))
                begin
                    done       = 1'b1;
                    drive      = idle_drive;
                    phase_next = '0;
                end
                else if (col != '0)
                begin
                    done       = 1'b1;
                    code       = {row8[3:0], col[3:0]};
                    drive      = idle_drive;
                    phase_next = '0;
                end
                else if (row >= rows)
                begin
                    done       = 1'b1;
                    drive      = idle_drive;
                    phase_next = '0;
                end
                else
                begin
                    phase_next = cur.phase + PHASE_W'(1);
                    drive      = (row8 < 8'd8) ? ~(8'd1 << row8[2:0]) : DRIVE_NONE;
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        nxt           = cur;
        nxt.phase     = phase_next;
        res.row_drive = drive;
        res.scan_done = done;
        res.scan_code = code;
        res.report    = 1'b0;
        if (done)
        begin
            if (code == cur.previous_code)
            begin
                if (cur.reported_code != code)
                begin
                    res.report        = 1'b1;
                    nxt.reported_code = code;
                end
            end
            else
            begin
                nxt.previous_code = code;
            end
        end
    end

endmodule

// ===== src/matrix_keypad_scanner.sv =====
// Keypad scanner with two-sample debounce.
// Input stream s_axis: one word per sample of the active-low sense lines, taken
// under the row drive of the previous result word. Output stream m_axis: one
// word per input word with the row drive for the next sample and, when a scan
// ends, the key code (matrix: row upper nibble, 1-based column lower; direct:
// 1-based line; zero for no key) and a report flag when the debounced code
// changes. scan_mode_we / scan_mode_wdata write the mode (full matrix, 4x4
// matrix, 8 direct lines, wide direct lines); write only while idle.
// The sample is held in an input register, the scan step is worked out in one
// pass and caught in the result register. One word is taken every cycle while
// the receiver keeps up; the two registers let the input accept a word while
// a finished result still waits on m_axis_tready.
// When the receiver stalls, the result word holds and the input register
// fills; s_axis_tready drops only once both are full.
// Reset clears the mode to full matrix, the scan phase to the idle read and
// both debounce codes to zero, and empties the pipeline.
module matrix_keypad_scanner
    import kps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               scan_mode_we,
    input  logic [1:0]         scan_mode_wdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [SENSE_W-1:0] s_axis_tdata,   // [15:0] sense_lines
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [15:0]        m_axis_tdata,   // [7:0] row_drive, [15:8] scan_code
    output logic [1:0]         m_axis_tuser    // [0] scan_done, [1] report
);

    logic [1:0]         mode_reg;
    logic               in_valid_reg;
    logic               in_valid_next;
    logic [SENSE_W-1:0] sense_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    kps_result_t        result_reg;
    kps_state_t         state_reg;
    kps_state_t         state_next;
    kps_result_t        step_res;
    logic               out_ready;
    logic               advance;
    logic               in_accept;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    kps_step u_step (
        .mode  (mode_reg),
        .sense (sense_reg),
        .cur   (state_reg),
        .nxt   (state_next),
        .res   (step_res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_MATRIX_FULL;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (scan_mode_we)
            begin
                mode_reg <= scan_mode_wdata;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            // advance the scan state only as a word moves into the result stage
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sense_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            result_reg <= step_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {result_reg.scan_code, result_reg.row_drive};
    assign m_axis_tuser  = {result_reg.report, result_reg.scan_done};

`ifndef NO_ASSERTIONS
    a_report_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("report without a finished scan");

    a_code_zero_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[15:8] == 8'h00)
        else $error("scan code set mid-scan");

    a_phase_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase <= PHASE_MAX)
        else $error("scan phase out of range");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("input stalled with room in the pipeline");

    a_reported_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && step_res.report) |=> $stable(state_reg.reported_code))
        else $error("reported code changed without a report");
`endif

endmodule
